### src/assert_macros.svh
// Assertion macros shared by the heap allocator RTL.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define FFHA_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define FFHA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, header layout, status codes,
// microcode types. No dependencies.
`default_nettype none

package ffha_pkg;

    // Heap geometry
    localparam int HEAP_WORDS = 1024;
    localparam int ADDR_W     = $clog2(HEAP_WORDS);
    localparam int POS_W      = ADDR_W + 1;
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int HDR_W      = SIZE_W + 1;

    // Request and result field widths
    localparam int BYTES_W    = 13;
    localparam int WORDS_W    = BYTES_W - 1;
    localparam int BADDR_W    = 10;
    localparam int DADDR_W    = 10;
    localparam int CMP_W      = ((WORDS_W > POS_W) ? WORDS_W : POS_W) + 1;

    // Stream widths
    localparam int S_TDATA_W  = ((BYTES_W + BADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DADDR_W + 7) / 8) * 8;

    // Microprogram step counter width
    localparam int STEP_W     = 4;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // Datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_WALK_RD,
        OP_WALK_EVAL,
        OP_ALLOC,
        OP_FREE_RD,
        OP_FREE_EVAL,
        OP_EMIT
    } op_t;

    // Jump condition of one microcode step
    typedef enum logic [2:0] {
        C_SEQ,
        C_ALWAYS,
        C_CLR_MORE,
        C_NO_REQ,
        C_FREE_CMD,
        C_FAIL,
        C_NOT_FIT,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Status returned from datapath to sequencer
    typedef struct packed {
        logic req;
        logic free_cmd;
        logic fail;
        logic not_fit;
        logic clr_more;
        logic out_busy;
    } dp_flags_t;

endpackage

`default_nettype wire

### src/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/ffha_sequencer.sv
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on ffha_pkg.
`default_nettype none

module ffha_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ffha_pkg::dp_flags_t flags,
    output ffha_pkg::ucode_t         ctrl
);

    // Step addresses
    localparam logic [ffha_pkg::STEP_W-1:0] S_CLEAR     = 4'd0;
    localparam logic [ffha_pkg::STEP_W-1:0] S_LOAD      = 4'd1;
    localparam logic [ffha_pkg::STEP_W-1:0] S_DISPATCH  = 4'd2;
    localparam logic [ffha_pkg::STEP_W-1:0] S_WALK_RD   = 4'd3;
    localparam logic [ffha_pkg::STEP_W-1:0] S_WALK_EVAL = 4'd4;
    localparam logic [ffha_pkg::STEP_W-1:0] S_ALLOC     = 4'd5;
    localparam logic [ffha_pkg::STEP_W-1:0] S_FREE_RD   = 4'd6;
    localparam logic [ffha_pkg::STEP_W-1:0] S_FREE_EVAL = 4'd7;
    localparam logic [ffha_pkg::STEP_W-1:0] S_EMIT      = 4'd8;
    localparam logic [ffha_pkg::STEP_W-1:0] S_RETURN    = 4'd9;

    logic [ffha_pkg::STEP_W-1:0] step_reg;
    logic [ffha_pkg::STEP_W-1:0] step_next;
    logic                        take_jump;

    // Control store
    function automatic ffha_pkg::ucode_t rom(input logic [ffha_pkg::STEP_W-1:0] s);
        ffha_pkg::ucode_t w;
        unique case (s)
            S_CLEAR:     w = '{ffha_pkg::OP_CLEAR,     ffha_pkg::C_CLR_MORE, S_CLEAR};
            S_LOAD:      w = '{ffha_pkg::OP_LOAD,      ffha_pkg::C_NO_REQ,   S_LOAD};
            S_DISPATCH:  w = '{ffha_pkg::OP_NOP,       ffha_pkg::C_FREE_CMD, S_FREE_RD};
            S_WALK_RD:   w = '{ffha_pkg::OP_WALK_RD,   ffha_pkg::C_FAIL,     S_EMIT};
            S_WALK_EVAL: w = '{ffha_pkg::OP_WALK_EVAL, ffha_pkg::C_NOT_FIT,  S_WALK_RD};
            S_ALLOC:     w = '{ffha_pkg::OP_ALLOC,     ffha_pkg::C_ALWAYS,   S_EMIT};
            S_FREE_RD:   w = '{ffha_pkg::OP_FREE_RD,   ffha_pkg::C_FAIL,     S_EMIT};
            S_FREE_EVAL: w = '{ffha_pkg::OP_FREE_EVAL, ffha_pkg::C_SEQ,      S_EMIT};
            S_EMIT:      w = '{ffha_pkg::OP_EMIT,      ffha_pkg::C_OUT_BUSY, S_EMIT};
            S_RETURN:    w = '{ffha_pkg::OP_NOP,       ffha_pkg::C_ALWAYS,   S_LOAD};
            default:     w = '{ffha_pkg::OP_NOP,       ffha_pkg::C_ALWAYS,   S_LOAD};
        endcase
        return w;
    endfunction

    assign ctrl = rom(step_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            ffha_pkg::C_SEQ:      take_jump = 1'b0;
            ffha_pkg::C_ALWAYS:   take_jump = 1'b1;
            ffha_pkg::C_CLR_MORE: take_jump = flags.clr_more;
            ffha_pkg::C_NO_REQ:   take_jump = !flags.req;
            ffha_pkg::C_FREE_CMD: take_jump = flags.free_cmd;
            ffha_pkg::C_FAIL:     take_jump = flags.fail;
            ffha_pkg::C_NOT_FIT:  take_jump = flags.not_fit;
            ffha_pkg::C_OUT_BUSY: take_jump = flags.out_busy;
            default:              take_jump = 1'b0;
        endcase
        step_next = take_jump ? ctrl.target : step_reg + 1'b1;
    end

    // Advance the step counter; start with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

### src/ffha_datapath.sv
// Datapath of the heap allocator: request registers, walk arithmetic, header RAM
// and result register. Depends on ffha_pkg, ffha_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ffha_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ffha_pkg::ucode_t                  ctrl,
    output ffha_pkg::dp_flags_t                    flags,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [ffha_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [ffha_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic      [1:0]                        m_axis_tuser
);

    localparam int AW = ffha_pkg::ADDR_W;
    localparam int PW = ffha_pkg::POS_W;
    localparam int CW = ffha_pkg::CMP_W;
    localparam int WW = ffha_pkg::WORDS_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam int DW = ffha_pkg::DADDR_W;
    localparam int BW = ffha_pkg::BADDR_W;
    localparam int YW = ffha_pkg::BYTES_W;

    // Request and walk registers
    logic                     free_cmd_reg, free_cmd_next;
    logic [WW-1:0]            words_reg, words_next;
    logic [BW-1:0]            baddr_reg, baddr_next;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [PW-1:0]            passed_reg, passed_next;
    ffha_pkg::status_t        status_reg, status_next;
    logic [DW-1:0]            res_addr_reg, res_addr_next;
    logic [AW-1:0]            clr_cnt_reg, clr_cnt_next;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    ffha_pkg::status_t        out_status_reg, out_status_next;
    logic [DW-1:0]            out_addr_reg, out_addr_next;

    // Header RAM ports
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    ffha_pkg::hdr_t           ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [ffha_pkg::HDR_W-1:0] ram_rdata;
    ffha_pkg::hdr_t           rd_hdr;

    // Arithmetic
    logic [YW-1:0]            in_bytes;
    logic [CW-1:0]            words_ext;
    logic [CW-1:0]            pos_ext;
    logic [CW-1:0]            data_pos;
    logic [CW-1:0]            baddr_ext;
    logic                     walk_fail;
    logic                     fit_fail;
    logic                     free_fail;
    logic                     found;
    logic                     out_busy;

    ffha_ram #(
        .WIDTH (ffha_pkg::HDR_W),
        .DEPTH (ffha_pkg::HEAP_WORDS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_hdr = ffha_pkg::hdr_t'(ram_rdata);

    // Walk and bound checks
    always_comb
    begin
        in_bytes  = s_axis_tdata[YW-1:0];
        words_ext = CW'(words_reg);
        pos_ext   = CW'(pos_reg);
        data_pos  = pos_ext + CW'(1);
        baddr_ext = CW'(baddr_reg);
        walk_fail = (pos_reg >= PW'(ffha_pkg::HEAP_WORDS))
                 || (CW'(passed_reg) + words_ext > CW'(ffha_pkg::HEAP_WORDS - 2));
        fit_fail  = (data_pos >= CW'(ffha_pkg::HEAP_WORDS))
                 || (words_ext > CW'(ffha_pkg::HEAP_WORDS) - data_pos);
        free_fail = (baddr_reg == '0) || (baddr_ext > CW'(ffha_pkg::HEAP_WORDS));
        found     = (rd_hdr.size == '0)
                 || (!rd_hdr.used && (CW'(rd_hdr.size) >= words_ext));
        out_busy  = out_valid_reg && !m_axis_tready;
    end

    // Flags for the sequencer
    always_comb
    begin
        flags.req      = s_axis_tvalid;
        flags.free_cmd = free_cmd_reg;
        flags.not_fit  = !found;
        flags.clr_more = (clr_cnt_reg != AW'(ffha_pkg::HEAP_WORDS - 1));
        flags.out_busy = out_busy;
        unique case (ctrl.op)
            ffha_pkg::OP_WALK_RD: flags.fail = walk_fail;
            ffha_pkg::OP_FREE_RD: flags.fail = free_fail;
            default:              flags.fail = 1'b0;
        endcase
    end

    // Execute the current control word
    always_comb
    begin
        free_cmd_next   = free_cmd_reg;
        words_next      = words_reg;
        baddr_next      = baddr_reg;
        pos_next        = pos_reg;
        passed_next     = passed_reg;
        status_next     = status_reg;
        res_addr_next   = res_addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg[AW-1:0];
        ram_wdata       = rd_hdr;
        ram_raddr       = pos_reg[AW-1:0];
        s_axis_tready   = 1'b0;

        unique case (ctrl.op)
            ffha_pkg::OP_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ffha_pkg::OP_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    free_cmd_next = (s_axis_tuser == ffha_pkg::CMD_FREE);
                    words_next    = WW'(in_bytes >> 2) + WW'(|in_bytes[1:0]);
                    baddr_next    = s_axis_tdata[YW+BW-1:YW];
                    pos_next      = '0;
                    passed_next   = '0;
                    status_next   = ffha_pkg::ST_OK;
                    res_addr_next = '0;
                end
            end
            ffha_pkg::OP_WALK_RD:
            begin
                if (walk_fail)
                begin
                    status_next = ffha_pkg::ST_NOMEM;
                end
            end
            ffha_pkg::OP_WALK_EVAL:
            begin
                // Step over a block that does not fit
                if (!found)
                begin
                    passed_next = passed_reg + rd_hdr.size;
                    pos_next    = pos_reg + rd_hdr.size + PW'(1);
                end
            end
            ffha_pkg::OP_ALLOC:
            begin
                if (fit_fail)
                begin
                    status_next = ffha_pkg::ST_NOMEM;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_wdata.used = 1'b1;
                    ram_wdata.size = (rd_hdr.used || rd_hdr.size == '0)
                                   ? SW'(words_ext) : rd_hdr.size;
                    status_next    = ffha_pkg::ST_OK;
                    res_addr_next  = DW'(data_pos);
                end
            end
            ffha_pkg::OP_FREE_RD:
            begin
                ram_raddr = AW'(baddr_ext - CW'(1));
                if (free_fail)
                begin
                    status_next = ffha_pkg::ST_BADFREE;
                end
            end
            ffha_pkg::OP_FREE_EVAL:
            begin
                ram_waddr = AW'(baddr_ext - CW'(1));
                if (rd_hdr.size == '0 || !rd_hdr.used)
                begin
                    status_next = ffha_pkg::ST_BADFREE;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_wdata.used = 1'b0;
                    status_next    = ffha_pkg::ST_OK;
                end
            end
            ffha_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = (status_reg == ffha_pkg::ST_OK) ? res_addr_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        free_cmd_reg   <= free_cmd_next;
        words_reg      <= words_next;
        baddr_reg      <= baddr_next;
        pos_reg        <= pos_next;
        passed_reg     <= passed_next;
        status_reg     <= status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ffha_pkg::M_TDATA_W'(out_addr_reg);
    assign m_axis_tuser  = out_status_reg;

    `FFHA_ASSERT_IMPL(a_we_steps, ram_we,
        (ctrl.op == ffha_pkg::OP_CLEAR || ctrl.op == ffha_pkg::OP_ALLOC
         || ctrl.op == ffha_pkg::OP_FREE_EVAL),
        "header write outside a writing step")
    `FFHA_ASSERT_NEXT(a_emit_loads, (ctrl.op == ffha_pkg::OP_EMIT && !out_busy),
        out_valid_reg, "emit step did not load the result")
    `FFHA_ASSERT_IMPL(a_err_addr_zero,
        (out_valid_reg && out_status_reg != ffha_pkg::ST_OK), (out_addr_reg == '0),
        "error result carries a data address")
    `FFHA_ASSERT_IMPL(a_walk_in_range, (ctrl.op == ffha_pkg::OP_WALK_EVAL),
        (pos_reg < PW'(ffha_pkg::HEAP_WORDS)), "header read beyond the heap")

endmodule

`default_nettype wire

### src/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: sequencer plus datapath.
// Depends on ffha_pkg, ffha_sequencer, ffha_datapath (and ffha_ram below it).
//
// Channel  | Dir | tdata (low bit up)                  | tuser
// s_axis   | in  | size_bytes[12:0], block_address[9:0] | command (0 alloc, 1 free)
// m_axis   | out | data_address[9:0]                    | status[1:0]
//
// After reset a clearing pass zeroes all 1024 headers; no request is taken meanwhile.
// Free: dispatch, header read, header release, emit, return to idle; word zero skips the release.
// Allocate: one header RAM read and one evaluation step per visited block, then alloc and emit.
// One request in flight; a stalled result holds in the output register.
// The next request is taken while an earlier result still waits on m_axis.
`default_nettype none

module first_fit_heap_allocator_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // size_bytes[12:0], block_address[22:13], zero pad
    input  wire logic [ffha_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // data_address[9:0], zero pad
    output logic      [ffha_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic      [1:0]                     m_axis_tuser
);

    ffha_pkg::ucode_t    ctrl;
    ffha_pkg::dp_flags_t flags;

    // Control store and step counter
    ffha_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Header RAM and arithmetic
    ffha_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .flags         (flags),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
